/* rtl/core/bufuart_pkg.sv */
// ----------------------------------------------------------------------------
// bufuart_pkg - shared definitions for the buffered serial-port queues
// Operation and status codes, default queue depth and the queue status
// bundle passed from each ring queue to the top level.
// ----------------------------------------------------------------------------
package bufuart_pkg;

   // default number of entries in each ring queue
   localparam int QUEUE_DEPTH = 32;

   // width of the reported byte counts
   localparam int COUNT_W = 6;

   // request operation codes
   localparam logic [1:0] OP_SW_WRITE = 2'd0;
   localparam logic [1:0] OP_SW_READ  = 2'd1;
   localparam logic [1:0] OP_LINE_RX  = 2'd2;
   localparam logic [1:0] OP_TX_READY = 2'd3;

   // response status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_QUEUE    = 2'd1;
   localparam logic [1:0] ST_DISARMED = 2'd2;

   // status of one ring queue
   typedef struct packed {
      logic               full;
      logic               empty;
      logic [COUNT_W-1:0] count;
   } q_stat_type;

endpackage

/* rtl/core/bufuart_queue.sv */
// ----------------------------------------------------------------------------
// bufuart_queue - one circular byte queue
// Byte store with write and read pointers and a fill count. The caller only
// pushes when not full and only pops when not empty. Pop data is registered.
// ----------------------------------------------------------------------------
module bufuart_queue #(
   parameter int DEPTH = bufuart_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [7:0]              push_data,
   input  logic                    pop,
   output logic [7:0]              pop_data,
   output bufuart_pkg::q_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [7:0]       store [DEPTH];
   logic [7:0]       pop_data_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W+bufuart_pkg::COUNT_W-1:0] count_ext;

   // advance pointers with wrap at the last entry
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_POS) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_POS) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write the pushed word into the store
   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

   // read the word at the head on pop
   always_ff @(posedge clock) begin
      if (pop) begin
         pop_data_ff <= store[rd_ptr_ff];
      end
   end

   assign pop_data   = pop_data_ff;
   assign count_ext  = {{bufuart_pkg::COUNT_W{1'b0}}, count_ff};
   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign stat.count = count_ext[bufuart_pkg::COUNT_W-1:0];

endmodule

/* rtl/core/buffered_uart_ring_queues_unit.sv */
// ----------------------------------------------------------------------------
// buffered_uart_ring_queues_unit - transmit and receive byte queues
// Software write/read and line receive/transmitter-ready operations on two
// ring queues, with the transmit-ready interrupt enable.
// ----------------------------------------------------------------------------
// One operation is taken per clock: busy is never raised, so start may be
// held high every cycle. The response appears with rsp_valid for exactly one
// cycle, in the cycle after the operation is taken, and cannot be held off. The
// latency is set by the registered read port of each queue store. Counts and
// the interrupt enable show the state after the latest operation. The stores
// need no clearing after reset; only words that were pushed are ever popped.
// ----------------------------------------------------------------------------
module buffered_uart_ring_queues_unit #(
   parameter int QUEUE_DEPTH = bufuart_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_operation,
   input  logic [7:0]                      req_data_in,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [7:0]                      rsp_data_out,
   output logic                            rsp_line_send,
   output logic                            rsp_tx_irq_armed,
   output logic [bufuart_pkg::COUNT_W-1:0] rsp_rx_count,
   output logic [bufuart_pkg::COUNT_W-1:0] rsp_tx_count
);

   bufuart_pkg::q_stat_type rx_stat, tx_stat;

   logic       accept;
   logic       tx_push, tx_pop, rx_push, rx_pop;
   logic [7:0] rx_pop_data, tx_pop_data;
   logic       irq_on_ff, irq_on_in;
   logic       valid_ff;
   logic [1:0] status_ff, status_in;
   logic       rx_pop_ff, tx_pop_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // decode the operation against queue status
   always_comb begin
      tx_push   = 1'b0;
      tx_pop    = 1'b0;
      rx_push   = 1'b0;
      rx_pop    = 1'b0;
      irq_on_in = irq_on_ff;
      status_in = bufuart_pkg::ST_DONE;
      case (req_operation)
         bufuart_pkg::OP_SW_WRITE: begin
            if (tx_stat.full) begin
               status_in = bufuart_pkg::ST_QUEUE;
            end else begin
               tx_push   = accept;
               irq_on_in = 1'b1;
            end
         end
         bufuart_pkg::OP_SW_READ: begin
            if (rx_stat.empty) begin
               status_in = bufuart_pkg::ST_QUEUE;
            end else begin
               rx_pop = accept;
            end
         end
         bufuart_pkg::OP_LINE_RX: begin
            if (rx_stat.full) begin
               status_in = bufuart_pkg::ST_QUEUE;
            end else begin
               rx_push = accept;
            end
         end
         bufuart_pkg::OP_TX_READY: begin
            if (!irq_on_ff) begin
               status_in = bufuart_pkg::ST_DISARMED;
            end else if (tx_stat.empty) begin
               status_in = bufuart_pkg::ST_QUEUE;
               irq_on_in = 1'b0;
            end else begin
               tx_pop = accept;
            end
         end
         default: begin
            status_in = bufuart_pkg::ST_DONE;
         end
      endcase
   end

   // hold interrupt enable and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         irq_on_ff <= 1'b0;
         valid_ff  <= 1'b0;
         rx_pop_ff <= 1'b0;
         tx_pop_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
         if (accept) begin
            irq_on_ff <= irq_on_in;
            rx_pop_ff <= rx_pop;
            tx_pop_ff <= tx_pop;
         end
      end
   end

   // capture the response status
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   bufuart_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_rx_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rx_push),
      .push_data (req_data_in),
      .pop       (rx_pop),
      .pop_data  (rx_pop_data),
      .stat      (rx_stat)
   );

   bufuart_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_tx_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tx_push),
      .push_data (req_data_in),
      .pop       (tx_pop),
      .pop_data  (tx_pop_data),
      .stat      (tx_stat)
   );

   // drive the response; data is zero when nothing was popped
   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_data_out     = rx_pop_ff ? rx_pop_data :
                             tx_pop_ff ? tx_pop_data : 8'd0;
   assign rsp_line_send    = tx_pop_ff;
   assign rsp_tx_irq_armed = irq_on_ff;
   assign rsp_rx_count     = rx_stat.count;
   assign rsp_tx_count     = tx_stat.count;

endmodule

/* rtl/core/bufuart_checker.sv */
// ----------------------------------------------------------------------------
// bufuart_checker - port-level checks for the buffered serial-port queues
// Watches the request and response ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module bufuart_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [1:0]                      rsp_status,
   input logic [7:0]                      rsp_data_out,
   input logic                            rsp_line_send,
   input logic                            rsp_tx_irq_armed,
   input logic [bufuart_pkg::COUNT_W-1:0] rsp_rx_count,
   input logic [bufuart_pkg::COUNT_W-1:0] rsp_tx_count
);

   // every taken word gives one response on the next cycle
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (!reset && start && !busy) |=> rsp_valid)
      else $error("response missing after taken word");

   // no response without a taken word
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response without taken word");

   // a byte sent to the line means a done pop with the interrupt still armed
   a_send_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_send) |->
         (rsp_status == bufuart_pkg::ST_DONE) && rsp_tx_irq_armed)
      else $error("line send with bad status or disarmed interrupt");

   // an ignored transmitter-ready leaves the interrupt off and no data
   a_disarmed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bufuart_pkg::ST_DISARMED) |->
         !rsp_tx_irq_armed && !rsp_line_send && (rsp_data_out == 8'd0))
      else $error("disarmed response carries data or armed interrupt");

   // a failed push or pop changes no count and returns no data
   a_fail_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bufuart_pkg::ST_DONE) |->
         (rsp_data_out == 8'd0) && !rsp_line_send
         && (rsp_rx_count == $past(rsp_rx_count))
         && (rsp_tx_count == $past(rsp_tx_count)))
      else $error("failed operation changed a count or returned data");

endmodule

bind buffered_uart_ring_queues_unit bufuart_checker u_bufuart_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_data_out     (rsp_data_out),
   .rsp_line_send    (rsp_line_send),
   .rsp_tx_irq_armed (rsp_tx_irq_armed),
   .rsp_rx_count     (rsp_rx_count),
   .rsp_tx_count     (rsp_tx_count)
);

/* dv/tb_buffered_uart_ring_queues_unit.sv */
// ----------------------------------------------------------------------------
// tb_buffered_uart_ring_queues_unit - testbench for the serial-port byte queues
// Drives software write/read, line receive and transmitter-ready words into
// the unit. A directed table covers reset state, extremes and the empty
// and disarmed cases. Random traffic follows in fill, drain and mixed
// segments. Every response is checked field by field against its table row's
// expected word or a predictor of both ring queues and the interrupt enable.
// ----------------------------------------------------------------------------
module tb_buffered_uart_ring_queues_unit;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int PHASE_WORDS  = 450;
   localparam int RXQ          = 0;
   localparam int TXQ          = 1;
   localparam int PRINT_LIMIT  = 40;

   // one response word as seen on the rsp_ ports
   typedef struct packed {
      logic [1:0]                      status;
      logic [7:0]                      data_out;
      logic                            line_send;
      logic                            irq_armed;
      logic [bufuart_pkg::COUNT_W-1:0] rx_count;
      logic [bufuart_pkg::COUNT_W-1:0] tx_count;
   } serial_word_type;

   // one row of the directed table
   typedef struct {
      logic [1:0]      op;
      logic [7:0]      data;
      bit              typed;
      serial_word_type want;
   } stim_row_type;

   typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} traffic_mode_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [1:0]                      req_operation;
   logic [7:0]                      req_data_in;
   logic                            rsp_valid;
   logic [1:0]                      rsp_status;
   logic [7:0]                      rsp_data_out;
   logic                            rsp_line_send;
   logic                            rsp_tx_irq_armed;
   logic [bufuart_pkg::COUNT_W-1:0] rsp_rx_count;
   logic [bufuart_pkg::COUNT_W-1:0] rsp_tx_count;

   // predicted state of both ring queues
   logic [7:0]  ring_data [2][bufuart_pkg::QUEUE_DEPTH];
   int unsigned ring_wr [2];
   int unsigned ring_rd [2];
   int unsigned ring_items [2];
   bit          ring_full [2];
   bit          irq_on;

   serial_word_type pending_responses [$];
   stim_row_type    directed_rows [$];
   bit              row_typed;
   serial_word_type row_want;
   int              gap_pct;
   int              error_count;
   int              cycle_count;

   buffered_uart_ring_queues_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .rsp_line_send    (rsp_line_send),
      .rsp_tx_irq_armed (rsp_tx_irq_armed),
      .rsp_rx_count     (rsp_rx_count),
      .rsp_tx_count     (rsp_tx_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // push one byte into a predicted queue, drop it when full
   function automatic logic [1:0] ring_push(int q, logic [7:0] b);
      if (ring_wr[q] == ring_rd[q] && ring_full[q]) return bufuart_pkg::ST_QUEUE;
      ring_data[q][ring_wr[q]] = b;
      ring_wr[q] = (ring_wr[q] + 1) % bufuart_pkg::QUEUE_DEPTH;
      ring_items[q]++;
      if (ring_wr[q] == ring_rd[q]) ring_full[q] = 1'b1;
      return bufuart_pkg::ST_DONE;
   endfunction

   // pop one byte from a predicted queue, report empty
   function automatic logic [1:0] ring_pop(int q, output logic [7:0] b);
      b = 8'h00;
      if (ring_wr[q] == ring_rd[q] && !ring_full[q]) return bufuart_pkg::ST_QUEUE;
      b = ring_data[q][ring_rd[q]];
      ring_rd[q] = (ring_rd[q] + 1) % bufuart_pkg::QUEUE_DEPTH;
      ring_items[q]--;
      ring_full[q] = 1'b0;
      return bufuart_pkg::ST_DONE;
   endfunction

   // advance the predicted queues by one operation and build its response
   function automatic serial_word_type predict_op(logic [1:0] op, logic [7:0] din);
      serial_word_type w;
      logic [7:0]      b;
      w = '0;
      b = 8'h00;
      case (op)
         bufuart_pkg::OP_SW_WRITE: begin
            w.status = ring_push(TXQ, din);
            if (w.status == bufuart_pkg::ST_DONE) irq_on = 1'b1;
         end
         bufuart_pkg::OP_SW_READ: begin
            w.status   = ring_pop(RXQ, b);
            w.data_out = b;
         end
         bufuart_pkg::OP_LINE_RX: begin
            w.status = ring_push(RXQ, din);
         end
         default: begin
            if (!irq_on) begin
               w.status = bufuart_pkg::ST_DISARMED;
            end else begin
               w.status   = ring_pop(TXQ, b);
               w.data_out = b;
               if (w.status == bufuart_pkg::ST_DONE) w.line_send = 1'b1;
               else irq_on = 1'b0;
            end
         end
      endcase
      w.irq_armed = irq_on;
      w.rx_count  = bufuart_pkg::COUNT_W'(ring_items[RXQ]);
      w.tx_count  = bufuart_pkg::COUNT_W'(ring_items[TXQ]);
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   // compare one field, treating unknown bits as a mismatch
   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // compare each response with the oldest expectation, then log new words
   always @(posedge clock) begin
      serial_word_type got;
      serial_word_type want;
      serial_word_type pred;
      if (!reset) begin
         if (rsp_valid) begin
            got = {rsp_status, rsp_data_out, rsp_line_send, rsp_tx_irq_armed,
                   rsp_rx_count, rsp_tx_count};
            if (pending_responses.size() == 0) begin
               report_mismatch("response with no word outstanding");
            end else begin
               want = pending_responses.pop_front();
               check_field("status", 8'(got.status), 8'(want.status));
               check_field("data_out", got.data_out, want.data_out);
               check_field("line_send", 8'(got.line_send), 8'(want.line_send));
               check_field("tx_irq_armed", 8'(got.irq_armed), 8'(want.irq_armed));
               check_field("rx_count", 8'(got.rx_count), 8'(want.rx_count));
               check_field("tx_count", 8'(got.tx_count), 8'(want.tx_count));
            end
         end
         if (start && !busy) begin
            pred = predict_op(req_operation, req_data_in);
            pending_responses.push_back(row_typed ? row_want : pred);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("buffered_uart_ring_queues_unit test failed");
         $finish;
      end
   end

   // offer one word, with a random gap first; returns at the next falling edge
   task automatic send_word(input logic [1:0] op, input logic [7:0] data,
                            input bit typed, input serial_word_type want);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      row_typed     = typed;
      row_want      = want;
      start         <= 1'b1;
      req_operation <= op;
      req_data_in   <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // hold start low until every response is in
   task automatic drain_responses();
      start <= 1'b0;
      do @(posedge clock); while (pending_responses.size() != 0);
      @(negedge clock);
   endtask

   task automatic add_row(input logic [1:0] op, input logic [7:0] data, input int typed,
                          input logic [1:0] st, input logic [7:0] dout, input int send,
                          input int irq, input int rx, input int tx);
      stim_row_type r;
      r.op    = op;
      r.data  = data;
      r.typed = (typed != 0);
      r.want  = {st, dout, 1'(send), 1'(irq), bufuart_pkg::COUNT_W'(rx),
                 bufuart_pkg::COUNT_W'(tx)};
      directed_rows.push_back(r);
   endtask

   function automatic logic [1:0] pick_op(traffic_mode_type mode);
      int r;
      r = $urandom_range(99);
      if (mode == MODE_FILL && r < 45) return bufuart_pkg::OP_SW_WRITE;
      if (mode == MODE_FILL && r < 90) return bufuart_pkg::OP_LINE_RX;
      if (mode == MODE_DRAIN && r < 45) return bufuart_pkg::OP_SW_READ;
      if (mode == MODE_DRAIN && r < 90) return bufuart_pkg::OP_TX_READY;
      return 2'($urandom_range(3));
   endfunction

   initial begin
      traffic_mode_type mode;
      int               sent;
      int               seg;
      int               seg_len;
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = bufuart_pkg::OP_SW_WRITE;
      req_data_in   = 8'h00;
      row_typed     = 1'b0;
      row_want      = '0;
      gap_pct       = 0;
      error_count   = 0;
      cycle_count   = 0;
      irq_on        = 1'b0;
      for (int q = 0; q < 2; q++) begin
         ring_wr[q]    = 0;
         ring_rd[q]    = 0;
         ring_items[q] = 0;
         ring_full[q]  = 1'b0;
      end

      // directed table: op, data, typed, status, data_out, send, irq, rx, tx
      add_row(bufuart_pkg::OP_TX_READY, 8'h00, 1, bufuart_pkg::ST_DISARMED, 8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_SW_READ,  8'hA5, 1, bufuart_pkg::ST_QUEUE,    8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_SW_WRITE, 8'hFF, 1, bufuart_pkg::ST_DONE,     8'h00, 0, 1, 0, 1);
      add_row(bufuart_pkg::OP_SW_WRITE, 8'h00, 1, bufuart_pkg::ST_DONE,     8'h00, 0, 1, 0, 2);
      add_row(bufuart_pkg::OP_TX_READY, 8'h5A, 1, bufuart_pkg::ST_DONE,     8'hFF, 1, 1, 0, 1);
      add_row(bufuart_pkg::OP_TX_READY, 8'hFF, 1, bufuart_pkg::ST_DONE,     8'h00, 1, 1, 0, 0);
      add_row(bufuart_pkg::OP_TX_READY, 8'h00, 1, bufuart_pkg::ST_QUEUE,    8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_TX_READY, 8'h00, 1, bufuart_pkg::ST_DISARMED, 8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_LINE_RX,  8'h00, 1, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 1, 0);
      add_row(bufuart_pkg::OP_LINE_RX,  8'hFF, 1, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 2, 0);
      add_row(bufuart_pkg::OP_LINE_RX,  8'h81, 0, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_SW_READ,  8'h00, 1, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 2, 0);
      add_row(bufuart_pkg::OP_SW_READ,  8'hFF, 1, bufuart_pkg::ST_DONE,     8'hFF, 0, 0, 1, 0);
      add_row(bufuart_pkg::OP_SW_READ,  8'h3C, 0, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_SW_READ,  8'h00, 1, bufuart_pkg::ST_QUEUE,    8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_SW_WRITE, 8'h7E, 0, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_LINE_RX,  8'h55, 0, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_SW_WRITE, 8'hC3, 0, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_TX_READY, 8'h00, 0, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_SW_READ,  8'h00, 0, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_TX_READY, 8'hAA, 0, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 0, 0);
      add_row(bufuart_pkg::OP_TX_READY, 8'h00, 0, bufuart_pkg::ST_DONE,     8'h00, 0, 0, 0, 0);

      // hold reset, release on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                   directed_rows[i].want);

      // random traffic: light gaps, heavy gaps, then back to back
      for (int ph = 0; ph < 3; ph++) begin
         gap_pct = (ph == 0) ? 30 : (ph == 1) ? 55 : 0;
         drain_responses();
         sent = 0;
         seg  = 0;
         while (sent < PHASE_WORDS) begin
            // open each phase with a fill segment on both queues, then a drain segment
            if (seg == 0) mode = MODE_FILL;
            else if (seg == 1) mode = MODE_DRAIN;
            else mode = traffic_mode_type'($urandom_range(2));
            seg_len = $urandom_range(60, 120);
            for (int k = 0; k < seg_len && sent < PHASE_WORDS; k++) begin
               send_word(pick_op(mode), 8'($urandom_range(255)), 1'b0, '0);
               sent++;
            end
            seg++;
         end
      end

      // wait out the last responses and watch for strays
      drain_responses();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("buffered_uart_ring_queues_unit test passed");
      end else begin
         $display("buffered_uart_ring_queues_unit test failed");
      end
      $finish;
   end

endmodule
